/* rtl/core/rdf_pkg.sv */
package rdf_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam int HASH_W = 32;
  localparam int RSSI_W = 8;
  localparam int MS_W   = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RSSI        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = CFG_IDX_W'(1);

  localparam logic signed [RSSI_W-1:0] MIN_RSSI_RST     = -8'sd90;
  localparam logic [MS_W-1:0]          REPEAT_INTVL_RST = 32'd5000;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [MS_W-1:0]   seen_ms;
  } entry_t;

endpackage

/* rtl/core/rdf_if.sv */
interface rdf_in_if;
  logic                                valid;
  logic                                ready;
  logic [rdf_pkg::HASH_W-1:0]          device_hash;
  logic signed [rdf_pkg::RSSI_W-1:0]   signal_strength;
  logic [rdf_pkg::MS_W-1:0]            now_ms;

  modport source (output valid, device_hash, signal_strength, now_ms, input ready);
  modport sink   (input valid, device_hash, signal_strength, now_ms, output ready);
endinterface

interface rdf_out_if;
  logic valid;
  logic ready;
  logic keep;

  modport source (output valid, keep, input ready);
  modport sink   (input valid, keep, output ready);
endinterface

interface rdf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rdf_pkg::CFG_IDX_W-1:0]    index;
  logic [rdf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/rdf_table.sv */
module rdf_table #(
  parameter int TableDepth = rdf_pkg::TABLE_DEPTH,
  parameter int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IdxW-1:0]      rd_addr,
  output rdf_pkg::entry_t      rd_data,
  input  logic                 wr_en,
  input  logic [IdxW-1:0]      wr_addr,
  input  rdf_pkg::entry_t      wr_data
);

  rdf_pkg::entry_t        mem [TableDepth];
  logic [TableDepth-1:0]  vld_r;
  rdf_pkg::entry_t        rd_word_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written entries read as the cleared value
  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

/* rtl/core/recent_device_report_filter.sv */
// Device report filter: each transfer on in_ch returns exactly one keep bit on out_ch, in order.
// A report below min_rssi skips the table and goes straight to the done state; any other report
// scans the hash table one entry per cycle through the single read port of the table memory,
// stopping early when the hash is found. One report is in work at a time; the next is taken as
// soon as the previous one sits in the output register.
// The table resets empty at once through per-entry valid bits; config writes on cfg_ch are
// always taken and should only be issued while no report is in work.
module recent_device_report_filter #(
  parameter int TableDepth = rdf_pkg::TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  rdf_in_if.sink       in_ch,
  rdf_out_if.source    out_ch,
  rdf_cfg_if.sink      cfg_ch
);

  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic signed [rdf_pkg::RSSI_W-1:0] min_rssi_r;
  logic [rdf_pkg::MS_W-1:0]          repeat_r;

  logic [rdf_pkg::HASH_W-1:0] hash_r;
  logic [rdf_pkg::MS_W-1:0]   now_r;

  logic [CntW-1:0]  issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic [IdxW-1:0]  proc_r, proc_nxt;
  logic             empty_fnd_r, empty_fnd_nxt;
  logic [IdxW-1:0]  empty_idx_r, empty_idx_nxt;
  logic [IdxW-1:0]  old_idx_r, old_idx_nxt;
  logic [rdf_pkg::MS_W-1:0] old_ms_r, old_ms_nxt;
  logic [IdxW-1:0]  slot_r, slot_nxt;
  logic             keep_r, keep_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_keep_r, out_keep_nxt;

  logic            in_acc;
  logic            below_floor;
  logic            rd_en;
  rdf_pkg::entry_t rd_data;
  rdf_pkg::entry_t wr_data;
  logic            wr_en;
  logic            hit;
  logic            recent;
  logic [rdf_pkg::MS_W-1:0] age;
  logic            out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign below_floor  = $signed(in_ch.signal_strength) < min_rssi_r;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.keep  = out_keep_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign rd_en   = (state_r == S_SCAN) && (issue_r < CntW'(TableDepth));
  assign wr_en   = (state_r == S_WRITE);
  assign wr_data = '{hash: hash_r, seen_ms: now_r};

  assign hit    = (rd_data.hash == hash_r);
  assign age    = now_r - rd_data.seen_ms;
  assign recent = (age < repeat_r);

  rdf_table #(
    .TableDepth (TableDepth),
    .IdxW       (IdxW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IdxW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_data)
  );

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    proc_nxt      = proc_r;
    empty_fnd_nxt = empty_fnd_r;
    empty_idx_nxt = empty_idx_r;
    old_idx_nxt   = old_idx_r;
    old_ms_nxt    = old_ms_r;
    slot_nxt      = slot_r;
    keep_nxt      = keep_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_keep_nxt  = out_keep_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          issue_nxt     = '0;
          proc_nxt      = '0;
          empty_fnd_nxt = 1'b0;
          keep_nxt      = 1'b0;
          state_nxt     = below_floor ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CntW'(1);
        end
        pend_nxt = rd_en;
        if (pend_r) begin
          if (hit) begin
            slot_nxt  = proc_r;
            keep_nxt  = !recent;
            state_nxt = recent ? S_DONE : S_WRITE;
          end else begin
            if (rd_data.hash == '0 && !empty_fnd_r) begin
              empty_fnd_nxt = 1'b1;
              empty_idx_nxt = proc_r;
            end
            if (proc_r == '0 || rd_data.seen_ms < old_ms_r) begin
              old_idx_nxt = proc_r;
              old_ms_nxt  = rd_data.seen_ms;
            end
            proc_nxt = proc_r + IdxW'(1);
            if (proc_r == IdxW'(TableDepth - 1)) begin
              slot_nxt  = empty_fnd_nxt ? empty_idx_nxt : old_idx_nxt;
              keep_nxt  = 1'b1;
              state_nxt = S_WRITE;
            end
          end
        end
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_keep_nxt  = keep_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      min_rssi_r  <= rdf_pkg::MIN_RSSI_RST;
      repeat_r    <= rdf_pkg::REPEAT_INTVL_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          rdf_pkg::CFG_MIN_RSSI:        min_rssi_r <= cfg_ch.data[rdf_pkg::RSSI_W-1:0];
          rdf_pkg::CFG_REPEAT_INTERVAL: repeat_r   <= cfg_ch.data[rdf_pkg::MS_W-1:0];
          default: begin
            // drop writes to unknown registers
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hash_r <= in_ch.device_hash;
      now_r  <= in_ch.now_ms;
    end
    issue_r     <= issue_nxt;
    proc_r      <= proc_nxt;
    empty_fnd_r <= empty_fnd_nxt;
    empty_idx_r <= empty_idx_nxt;
    old_idx_r   <= old_idx_nxt;
    old_ms_r    <= old_ms_nxt;
    slot_r      <= slot_nxt;
    keep_r      <= keep_nxt;
    out_keep_r  <= out_keep_nxt;
  end

`ifndef SYNTHESIS
  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted report did not start work");

  a_below_floor_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && below_floor) |=> (state_r == S_DONE && !keep_r))
    else $error("report below floor not dropped at once");

  a_write_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> keep_r)
    else $error("table written for a dropped report");

  a_write_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (state_r == S_DONE))
    else $error("write-back not followed by result");
`endif

endmodule
